// ===== rtl/core/rmq_pkg.sv =====
// Package for the rotation matrix to quaternion block: formats and sizes.
// No dependencies; used by rmq_quot, the top level and the testbench.
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    // root argument in [ONE, 4*ONE], times ONE
    localparam int RAD_W     = 2 * FRAC_BITS + 3;
    localparam int ROOT_W    = (RAD_W + 1) / 2;
    // numerator magnitude is at most 2*ONE
    localparam int NUM_W     = FRAC_BITS + 2;
    // quotient of (mag*ONE + r) / 2r, at most 2*ONE/2
    localparam int QUO_W     = FRAC_BITS + 2;
    localparam int DIV_W     = NUM_W + FRAC_BITS + 1;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DV_STEPS  = QUO_W;

    typedef logic signed [15:0] elem_t;

    // case of the conversion: which component is the half root
    localparam logic [1:0] SEL_W = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;
    localparam logic [1:0] SEL_Z = 2'd3;

    typedef struct packed {
        logic [1:0]        sel;
        logic [2:0]        neg;
        logic [2:0][NUM_W-1:0] mag;
    } side_t;
endpackage

// ===== rtl/core/rmq_quot.sv =====
// Pipelined restoring divider: q = (mag*ONE + r) / (2r), one bit a stage.
// Depends on rmq_pkg.
module rmq_quot (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rmq_pkg::NUM_W-1:0]   mag,
    input  logic [rmq_pkg::ROOT_W-1:0]  root,
    output logic [rmq_pkg::QUO_W-1:0]   quo
);
    import rmq_pkg::*;

    localparam int DEN_W = ROOT_W + 1;

    logic [DIV_W-1:0] rem_reg  [DV_STEPS+1];
    logic [DEN_W-1:0] den_reg  [DV_STEPS+1];
    logic [QUO_W-1:0] q_reg    [DV_STEPS+1];

    // load the dividend and the doubled root
    always_comb begin
        rem_reg[0] = DIV_W'({mag, {FRAC_BITS{1'b0}}}) + DIV_W'(root);
        den_reg[0] = {root, 1'b0};
        q_reg[0]   = '0;
    end

    // one quotient bit per stage, from the top
    for (genvar k = 0; k < DV_STEPS; k++) begin : g_step
        localparam int SH = DV_STEPS - 1 - k;
        logic [DIV_W+DEN_W-1:0] trial;
        logic                   take;
        assign trial = (DIV_W+DEN_W)'(den_reg[k]) << SH;
        assign take  = (DIV_W+DEN_W)'(rem_reg[k]) >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? rem_reg[k] - DIV_W'(trial) : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_reg[k] | (take ? QUO_W'(1) << SH : '0);
            end
        end
    end

    assign quo = q_reg[DV_STEPS];
endmodule

// ===== rtl/core/rotation_matrix_to_quaternion_top.sv =====
// Top level: rotation matrix (Q1.14) to unit quaternion, fully pipelined.
// Depends on rmq_pkg and rmq_quot.
//
// Usage: a request on s_axis carries the nine matrix elements; one
// quaternion leaves on m_axis for each request, in order. Elements are
// clamped to +-1.0 first, the case (positive trace or largest diagonal)
// is picked, the root argument is formed and a restoring square root
// runs one result bit a stage (16 stages), then three dividers run one
// quotient bit a stage (16 stages) in parallel.
// A request passes the clamp, case, root, divider and output registers in turn.
// Throughput: one request per cycle unless the receiver stalls; the whole pipe is one shift line.
// When the receiver stalls (m_axis_tready low with valid output) the
// entire pipe holds; s_axis_tready is high whenever the output register
// is empty or is being taken. Reset clears all valid bits; data
// registers keep whatever they hold.
module rotation_matrix_to_quaternion_top (
    input  logic         aclk,
    input  logic         aresetn,
    // tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [143:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: qw, qx, qy, qz (16 bits each)
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);
    import rmq_pkg::*;

    localparam int DEPTH = 2 + SQ_STEPS + DV_STEPS;
    localparam int SQW   = RAD_W + 2;

    logic en;
    logic [DEPTH:0] vld_reg;

    // the pipe advances when the output slot is free or taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-1:0], s_axis_tvalid};
        end
    end

    // stage 1: clamp the elements
    logic signed [15:0] m_reg [9];
    for (genvar i = 0; i < 9; i++) begin : g_clamp
        logic signed [15:0] e;
        assign e = s_axis_tdata[16*i +: 16];
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[i] <= (e > 16'sd16384) ? 16'sd16384 :
                            (e < -16'sd16384) ? -16'sd16384 : e;
            end
        end
    end

    // stage 2: pick the case, form root argument and numerators
    logic signed [17:0] tr, a_c;
    logic signed [16:0] d0, d1, d2, p0, p1, p2;
    logic [1:0] sel_c;
    logic signed [16:0] n_c [3];
    always_comb begin
        tr = 18'(m_reg[0]) + 18'(m_reg[4]) + 18'(m_reg[8]);
        d0 = 17'(m_reg[7]) - 17'(m_reg[5]);
        d1 = 17'(m_reg[2]) - 17'(m_reg[6]);
        d2 = 17'(m_reg[3]) - 17'(m_reg[1]);
        p0 = 17'(m_reg[1]) + 17'(m_reg[3]);
        p1 = 17'(m_reg[2]) + 17'(m_reg[6]);
        p2 = 17'(m_reg[5]) + 17'(m_reg[7]);
        if (tr > 0) begin
            sel_c = SEL_W;
            a_c   = tr + 18'sd16384;
            n_c[0] = d0; n_c[1] = d1; n_c[2] = d2;
        end else if (m_reg[0] > m_reg[4] && m_reg[0] > m_reg[8]) begin
            sel_c = SEL_X;
            a_c   = 18'sd16384 + 18'(m_reg[0]) - 18'(m_reg[4]) - 18'(m_reg[8]);
            n_c[0] = d0; n_c[1] = p0; n_c[2] = p1;
        end else if (m_reg[4] > m_reg[8]) begin
            sel_c = SEL_Y;
            a_c   = 18'sd16384 + 18'(m_reg[4]) - 18'(m_reg[0]) - 18'(m_reg[8]);
            n_c[0] = d1; n_c[1] = p0; n_c[2] = p2;
        end else begin
            sel_c = SEL_Z;
            a_c   = 18'sd16384 + 18'(m_reg[8]) - 18'(m_reg[0]) - 18'(m_reg[4]);
            n_c[0] = d2; n_c[1] = p1; n_c[2] = p2;
        end
    end

    side_t             sd_reg [SQ_STEPS+1];
    logic [RAD_W-1:0]  rad_reg [SQ_STEPS+1];
    logic [ROOT_W-1:0] rt_reg  [SQ_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0].sel <= sel_c;
            for (int j = 0; j < 3; j++) begin
                sd_reg[0].neg[j] <= n_c[j][16];
                sd_reg[0].mag[j] <= NUM_W'(n_c[j][16] ? -n_c[j] : n_c[j]);
            end
            rad_reg[0] <= RAD_W'({a_c[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}});
            rt_reg[0]  <= '0;
        end
    end

    // square root, one result bit a stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - k;
        logic [SQW-1:0] trial;
        logic           take;
        assign trial = ((SQW'(rt_reg[k]) << 1) | SQW'(1) << B) << B;
        assign take  = SQW'(rad_reg[k]) >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k+1] <= take ? rad_reg[k] - RAD_W'(trial) : rad_reg[k];
                rt_reg[k+1]  <= rt_reg[k] | (take ? ROOT_W'(1) << B : '0);
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    // dividers and a side line of the same depth
    logic [ROOT_W-1:0] root;
    logic [QUO_W-1:0]  quo [3];
    assign root = (rt_reg[SQ_STEPS] == '0) ? ROOT_W'(1) : rt_reg[SQ_STEPS];

    for (genvar j = 0; j < 3; j++) begin : g_div
        rmq_quot u_quot (
            .aclk (aclk),
            .en   (en),
            .mag  (sd_reg[SQ_STEPS].mag[j]),
            .root (root),
            .quo  (quo[j])
        );
    end

    logic [1:0]        sel_reg  [DV_STEPS+1];
    logic [2:0]        neg_reg  [DV_STEPS+1];
    logic [ROOT_W-1:0] half_reg [DV_STEPS+1];
    always_comb begin
        sel_reg[0]  = sd_reg[SQ_STEPS].sel;
        neg_reg[0]  = sd_reg[SQ_STEPS].neg;
        half_reg[0] = ROOT_W'((ROOT_W+1)'(root) + 1'b1 >> 1);
    end
    for (genvar k = 0; k < DV_STEPS; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                sel_reg[k+1]  <= sel_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                half_reg[k+1] <= half_reg[k];
            end
        end
    end

    // sign, saturate to +-1.0 and place the components
    logic signed [15:0] c [3];
    logic signed [15:0] hr;
    logic [63:0]        q_c;
    logic [63:0]        out_reg;
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c[j] = (quo[j] > QUO_W'(ONE)) ? 16'sd16384 : 16'(quo[j]);
            if (neg_reg[DV_STEPS][j]) begin
                c[j] = -c[j];
            end
        end
        hr = (half_reg[DV_STEPS] > ROOT_W'(ONE)) ? 16'sd16384 : 16'(half_reg[DV_STEPS]);
        case (sel_reg[DV_STEPS])
            SEL_W:   q_c = {c[2], c[1], c[0], hr};
            SEL_X:   q_c = {c[2], c[1], hr, c[0]};
            SEL_Y:   q_c = {c[2], hr, c[1], c[0]};
            default: q_c = {hr, c[2], c[1], c[0]};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= q_c;
        end
    end
    assign m_axis_tdata = out_reg;

    // a stalled output must hold its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // input is taken whenever the output slot is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output");
    // an accepted request sets the first valid bit of the pipe
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && m_axis_tready |=> vld_reg[0])
        else $error("accepted request lost");
endmodule

// ===== bench/testbench.sv =====
// Testbench for rotation_matrix_to_quaternion_top: random and corner matrices in,
// quaternions out, checked against a fixed-point predictor. Depends on rmq_pkg.
`timescale 1ns / 100ps

class quat_scoreboard;
    logic [63:0] pending_quats[$];
    int          errors;

    function automatic logic [63:0] isqrt_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint sat_one(longint v);
        longint one;
        one = longint'(rmq_pkg::ONE);
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic longint root_arg(longint a);
        logic [63:0] r;
        if (a < 0) a = 0;
        r = isqrt_floor(64'(a) << rmq_pkg::FRAC_BITS);
        return (r == 0) ? 1 : longint'(r);
    endfunction

    // n * ONE / 2r, rounded half away from zero
    function automatic longint div_round(longint n, longint r);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q   = ((mag << rmq_pkg::FRAC_BITS) + r) / (2 * r);
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [63:0] to_quat(logic [143:0] mat);
        longint m[9];
        longint q[4];
        longint one;
        longint tr;
        longint r;
        logic [63:0] res;
        one = longint'(rmq_pkg::ONE);
        for (int i = 0; i < 9; i++) m[i] = sat_one(longint'($signed(mat[16*i +: 16])));
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            r = root_arg(tr + one);
            q[0] = (r + 1) >>> 1;
            q[1] = div_round(m[7] - m[5], r);
            q[2] = div_round(m[2] - m[6], r);
            q[3] = div_round(m[3] - m[1], r);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            r = root_arg(one + m[0] - m[4] - m[8]);
            q[0] = div_round(m[7] - m[5], r);
            q[1] = (r + 1) >>> 1;
            q[2] = div_round(m[1] + m[3], r);
            q[3] = div_round(m[2] + m[6], r);
        end else if (m[4] > m[8]) begin
            r = root_arg(one + m[4] - m[0] - m[8]);
            q[0] = div_round(m[2] - m[6], r);
            q[1] = div_round(m[1] + m[3], r);
            q[2] = (r + 1) >>> 1;
            q[3] = div_round(m[5] + m[7], r);
        end else begin
            r = root_arg(one + m[8] - m[0] - m[4]);
            q[0] = div_round(m[3] - m[1], r);
            q[1] = div_round(m[2] + m[6], r);
            q[2] = div_round(m[5] + m[7], r);
            q[3] = (r + 1) >>> 1;
        end
        for (int i = 0; i < 4; i++) res[16*i +: 16] = 16'(sat_one(q[i]));
        return res;
    endfunction

    function void note_request(logic [143:0] mat);
        pending_quats.push_back(to_quat(mat));
    endfunction

    function void check_quat(logic [63:0] got);
        logic [63:0] exp_q;
        if (pending_quats.size() == 0) begin
            $display("%0t: unexpected quaternion %h", $time, got);
            errors++;
            return;
        end
        exp_q = pending_quats.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (got[16*i +: 16] !== exp_q[16*i +: 16]) begin
                $display("%0t: component %0d expected %0d actual %0d", $time, i,
                         $signed(exp_q[16*i +: 16]), $signed(got[16*i +: 16]));
                errors++;
            end
        end
    endfunction
endclass

module testbench;
    import rmq_pkg::*;

    localparam int LATENCY = 35;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [143:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;

    quat_scoreboard quat_sb = new();
    logic [143:0] matrix_queue[$];
    bit           feed_done = 0;

    rotation_matrix_to_quaternion_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #1 aclk = ~aclk;

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) quat_sb.note_request(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) quat_sb.check_quat(m_axis_tdata);
    end

    // receiver stall pattern: rotates between always ready, mostly ready and mostly stalled
    initial begin
        int mode;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            mode = int'(($time / 400) % 3);
            if (mode == 0) m_axis_tready <= 1'b1;
            else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 9) < 3);
        end
    end

    function automatic logic [15:0] rand_elem();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'($urandom());
        if (k == 1) return 16'(ONE);
        if (k == 2) return 16'(-ONE);
        return 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endfunction

    // random matrix; half of them get one dominant diagonal element and two non-positive ones
    function automatic logic [143:0] rand_matrix();
        logic [143:0] mat;
        int dom;
        for (int i = 0; i < 9; i++) mat[16*i +: 16] = rand_elem();
        if ($urandom_range(0, 1)) begin
            dom = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                mat[16*(4*i) +: 16] = (i == dom) ? 16'($urandom_range(ONE / 2, ONE))
                                                 : 16'(-$signed($urandom_range(0, ONE)));
        end
        return mat;
    endfunction

    function automatic logic [143:0] diag(int a, int b, int c);
        logic [143:0] mat;
        mat = '0;
        mat[0 +: 16]   = 16'(a);
        mat[64 +: 16]  = 16'(b);
        mat[128 +: 16] = 16'(c);
        return mat;
    endfunction

    task automatic send_matrix(logic [143:0] mat);
        s_axis_tdata  <= mat;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (quat_sb.pending_quats.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int burst;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: identity, trace paths, diagonal ties, extremes, out of range
        matrix_queue.push_back(diag(ONE, ONE, ONE));
        matrix_queue.push_back(diag(ONE, -ONE, -ONE));
        matrix_queue.push_back(diag(-ONE, ONE, -ONE));
        matrix_queue.push_back(diag(-ONE, -ONE, ONE));
        matrix_queue.push_back(diag(-ONE, -ONE, -ONE));
        matrix_queue.push_back(diag(0, 0, 0));
        matrix_queue.push_back(diag(-100, -100, -100));
        matrix_queue.push_back(diag(5, -5, 0));
        matrix_queue.push_back(diag(1, 0, 0));
        matrix_queue.push_back({9{16'h7fff}});
        matrix_queue.push_back({9{16'h8000}});
        matrix_queue.push_back({9{16'hffff}});
        matrix_queue.push_back({9{16'(ONE)}});
        matrix_queue.push_back({9{16'(-ONE)}});
        matrix_queue.push_back({16'(-ONE), 16'(ONE), 16'(-ONE), 16'(ONE), 16'(-ONE),
                                16'(ONE), 16'(-ONE), 16'(ONE), 16'(-ONE)});
        matrix_queue.push_back({16'h0, 16'h0, 16'(ONE), 16'h0, 16'(-ONE),
                                16'h0, 16'(ONE), 16'h0, 16'(-ONE)});
        matrix_queue.push_back({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        foreach (matrix_queue[i]) send_matrix(matrix_queue[i]);
        s_axis_tvalid <= 1'b0;

        // hold off until everything issued so far has come back
        wait_drained();

        // random bursts with gaps
        for (int n = 0; n < 900; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 900; k++, n++) send_matrix(rand_matrix());
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(negedge aclk);
        feed_done = 1;
    end

    initial begin
        wait (feed_done);
        if (quat_sb.errors == 0 && quat_sb.pending_quats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
